FILE: rtl/jac_pkg.sv
`default_nettype none

package jac_pkg;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int VALUE_W  = 8;
  localparam int SUM_W    = 19;  // holds 128 * 4095 without wrapping

  // Fixed constants of the conditioning math
  localparam int unsigned DEFAULT_CENTER  = 2048;
  localparam int unsigned CENTER_LIMIT    = 4000;
  localparam int unsigned FULL_SCALE      = 100;
  localparam int unsigned HALF_SPAN_SHIFT = 11;   // divide by 2048
  localparam int unsigned DEADZONE_RESET  = 100;

  // Item kinds
  typedef enum logic {
    KIND_MEASURE = 1'b0,
    KIND_CAL     = 1'b1
  } kind_t;

endpackage

`default_nettype wire

FILE: rtl/jac_if.sv
`default_nettype none

// Sample channel: one converter reading pair plus button level per transfer
interface jac_in_if import jac_pkg::*; ();
  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [SAMPLE_W-1:0] x_sample;
  logic [SAMPLE_W-1:0] y_sample;
  logic                button_level;

  modport source (output valid, kind, x_sample, y_sample, button_level, input ready);
  modport sink   (input valid, kind, x_sample, y_sample, button_level, output ready);
endinterface

// Result channel: scaled axes, button, calibration status and centers
interface jac_out_if import jac_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  x_value;
  logic signed [VALUE_W-1:0]  y_value;
  logic                       button_down;
  logic                       calibration_done;
  logic [SAMPLE_W-1:0]        center_x_out;
  logic [SAMPLE_W-1:0]        center_y_out;

  modport source (output valid, x_value, y_value, button_down, calibration_done,
                  center_x_out, center_y_out, input ready);
  modport sink   (input valid, x_value, y_value, button_down, calibration_done,
                  center_x_out, center_y_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/joystick_axis_conditioner.sv
// A transferred sample passes through the input register and then the result register to the output.
// Throughput: one item per cycle while results.ready is high; the center/sum update and
// the divide-by-CAL_SAMPLES reciprocal multiply sit in the single stage between both registers.
// Reset (rst, synchronous): centers to 2048, sums and sample count to zero,
// deadzone to 100, both pipeline registers empty.
`default_nettype none

module joystick_axis_conditioner import jac_pkg::*; #(
  parameter int CAL_SAMPLES = 100
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [SAMPLE_W-1:0] cfg_wdata,
  jac_in_if.sink                   samples,
  jac_out_if.source                results
);

  // Calibration count and exact reciprocal for sum / CAL_SAMPLES
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int SHIFT   = SUM_W + $clog2(CAL_SAMPLES);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // Offset from center, deadzone, scale by 100/2048 toward zero, clamp
  function automatic logic signed [VALUE_W-1:0] scale_axis(
    input logic [SAMPLE_W-1:0] sample,
    input logic [SAMPLE_W-1:0] center,
    input logic [SAMPLE_W-1:0] dz
  );
    logic signed [SAMPLE_W:0] off;
    logic [SAMPLE_W-1:0]      mag;
    logic [SUM_W-1:0]         prod;
    logic [VALUE_W-1:0]       quo;
    logic [VALUE_W-2:0]       lim;
    off  = $signed({1'b0, sample}) - $signed({1'b0, center});
    mag  = off[SAMPLE_W] ? SAMPLE_W'(-off) : off[SAMPLE_W-1:0];
    // mag * 100 = mag*64 + mag*32 + mag*4
    prod = (SUM_W'(mag) << 6) + (SUM_W'(mag) << 5) + (SUM_W'(mag) << 2);
    quo  = prod[HALF_SPAN_SHIFT +: VALUE_W];
    lim  = (quo > VALUE_W'(FULL_SCALE)) ? (VALUE_W-1)'(FULL_SCALE) : quo[VALUE_W-2:0];
    if (mag < dz) begin
      lim = '0;
    end
    return off[SAMPLE_W] ? -$signed({1'b0, lim}) : $signed({1'b0, lim});
  endfunction

  // Configuration and calibration state
  logic [SAMPLE_W-1:0] deadzone;
  logic [SAMPLE_W-1:0] center_x, center_y;
  logic [SAMPLE_W-1:0] center_x_next, center_y_next;
  logic [SUM_W-1:0]    sum_x, sum_y;
  logic [SUM_W-1:0]    sum_x_next, sum_y_next;
  logic [CNT_W-1:0]    cal_count, cal_count_next;

  // Input register
  logic                s_valid;
  kind_t               s_kind;
  logic [SAMPLE_W-1:0] s_x, s_y;
  logic                s_button;

  // Result register
  logic                       o_valid;
  logic signed [VALUE_W-1:0]  o_x, o_y;
  logic                       o_button;
  logic                       o_done;
  logic [SAMPLE_W-1:0]        o_cx, o_cy;

  // Stage datapath
  logic                      advance;
  logic signed [VALUE_W-1:0] x_val, y_val;
  logic [SUM_W-1:0]          sum_x_add, sum_y_add;
  logic [CNT_W:0]            count_inc;
  logic                      cal_end;
  logic [PROD_W-1:0]         prod_x, prod_y;
  logic [SAMPLE_W-1:0]       mean_x, mean_y;
  logic                      done;

  // Flow control: the stage moves into the result register when it is free or drained
  assign advance       = s_valid && (!o_valid || results.ready);
  assign samples.ready = !s_valid || advance;

  // Deadzone register
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= SAMPLE_W'(DEADZONE_RESET);
    end else if (cfg_we) begin
      deadzone <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (samples.ready) begin
      s_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s_kind   <= samples.kind;
      s_x      <= samples.x_sample;
      s_y      <= samples.y_sample;
      s_button <= samples.button_level;
    end
  end

  // Scaling and calibration for the item in the stage
  always_comb begin
    x_val          = '0;
    y_val          = '0;
    done           = 1'b0;
    center_x_next  = center_x;
    center_y_next  = center_y;
    sum_x_next     = sum_x;
    sum_y_next     = sum_y;
    cal_count_next = cal_count;

    sum_x_add = sum_x + SUM_W'(s_x);
    sum_y_add = sum_y + SUM_W'(s_y);
    count_inc = {1'b0, cal_count} + (CNT_W+1)'(1);
    cal_end   = (count_inc == (CNT_W+1)'(CAL_SAMPLES));
    prod_x    = PROD_W'(sum_x_add) * PROD_W'(RECIP);
    prod_y    = PROD_W'(sum_y_add) * PROD_W'(RECIP);
    mean_x    = prod_x[SHIFT +: SAMPLE_W];
    mean_y    = prod_y[SHIFT +: SAMPLE_W];

    case (s_kind)
      KIND_MEASURE: begin
        x_val = scale_axis(s_x, center_x, deadzone);
        y_val = scale_axis(s_y, center_y, deadzone);
      end
      KIND_CAL: begin
        if (cal_end) begin
          done           = 1'b1;
          sum_x_next     = '0;
          sum_y_next     = '0;
          cal_count_next = '0;
          // Out-of-range mean on either axis falls back to the default center
          if (mean_x > SAMPLE_W'(CENTER_LIMIT) || mean_y > SAMPLE_W'(CENTER_LIMIT)) begin
            center_x_next = SAMPLE_W'(DEFAULT_CENTER);
            center_y_next = SAMPLE_W'(DEFAULT_CENTER);
          end else begin
            center_x_next = mean_x;
            center_y_next = mean_y;
          end
        end else begin
          sum_x_next     = sum_x_add;
          sum_y_next     = sum_y_add;
          cal_count_next = count_inc[CNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // State update as the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x  <= SAMPLE_W'(DEFAULT_CENTER);
      center_y  <= SAMPLE_W'(DEFAULT_CENTER);
      sum_x     <= '0;
      sum_y     <= '0;
      cal_count <= '0;
    end else if (advance) begin
      center_x  <= center_x_next;
      center_y  <= center_y_next;
      sum_x     <= sum_x_next;
      sum_y     <= sum_y_next;
      cal_count <= cal_count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      o_x      <= x_val;
      o_y      <= y_val;
      o_button <= ~s_button;
      o_done   <= done;
      o_cx     <= center_x_next;
      o_cy     <= center_y_next;
    end
  end

  assign results.valid            = o_valid;
  assign results.x_value          = o_x;
  assign results.y_value          = o_y;
  assign results.button_down      = o_button;
  assign results.calibration_done = o_done;
  assign results.center_x_out     = o_cx;
  assign results.center_y_out     = o_cy;

endmodule

`default_nettype wire

FILE: bench/tb_joystick_axis_conditioner.sv
`timescale 1ns / 100ps

module tb_joystick_axis_conditioner;
  import jac_pkg::*;

  localparam int CAL_SAMPLES    = 100;
  localparam int FULL_DEFL      = FULL_SCALE;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 220;
  localparam int DIRECTED_COUNT = 20;
  localparam int MAX_REPORTS    = 10;

  // one output transfer
  typedef struct packed {
    logic signed [VALUE_W-1:0] x_value;
    logic signed [VALUE_W-1:0] y_value;
    logic                      button_down;
    logic                      calibration_done;
    logic [SAMPLE_W-1:0]       center_x;
    logic [SAMPLE_W-1:0]       center_y;
  } reading_t;

  // directed stimulus row; typed rows carry their expected reading
  typedef struct {
    kind_t               kind;
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic                button_level;
    bit                  typed;
    reading_t            want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [SAMPLE_W-1:0] cfg_wdata;

  jac_in_if  samples_if ();
  jac_out_if results_if ();

  joystick_axis_conditioner #(.CAL_SAMPLES(CAL_SAMPLES)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .samples   (samples_if),
    .results   (results_if)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // conditioner state as predicted
  logic [SAMPLE_W-1:0] ctr_x = SAMPLE_W'(DEFAULT_CENTER);
  logic [SAMPLE_W-1:0] ctr_y = SAMPLE_W'(DEFAULT_CENTER);
  int                  acc_x = 0;
  int                  acc_y = 0;
  int                  acc_n = 0;
  logic [SAMPLE_W-1:0] dz_now;

  reading_t expected_readings [$];
  int       mismatches;
  int       items_sent;
  int       stall_cycles;
  int       src_idle, snk_idle;

  // typed expectation travelling with the payload
  bit       cur_typed;
  reading_t cur_want;

  wire in_xfer  = samples_if.valid && samples_if.ready;
  wire out_xfer = results_if.valid && results_if.ready;

  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{KIND_MEASURE, 12'd2048, 12'd2048, 1'b1, 1'b1, '{8'sd0, 8'sd0, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd4095, 12'd0,    1'b0, 1'b1, '{8'sd99, -8'sd100, 1'b1, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd0,    12'd4095, 1'b1, 1'b1, '{-8'sd100, 8'sd99, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd2147, 12'd1949, 1'b0, 1'b1, '{8'sd0, 8'sd0, 1'b1, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd2148, 12'd1948, 1'b1, 1'b0, '0},
    '{KIND_MEASURE, 12'd2047, 12'd2049, 1'b0, 1'b1, '{8'sd0, 8'sd0, 1'b1, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd3000, 12'd1000, 1'b1, 1'b0, '0},
    '{KIND_MEASURE, 12'd4095, 12'd4095, 1'b0, 1'b1, '{8'sd99, 8'sd99, 1'b1, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd0,    12'd0,    1'b1, 1'b1, '{-8'sd100, -8'sd100, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_CAL,     12'd4095, 12'd4095, 1'b1, 1'b1, '{8'sd0, 8'sd0, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_CAL,     12'd0,    12'd0,    1'b0, 1'b1, '{8'sd0, 8'sd0, 1'b1, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd2048, 12'd4095, 1'b1, 1'b1, '{8'sd0, 8'sd99, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_CAL,     12'd123,  12'd3999, 1'b1, 1'b1, '{8'sd0, 8'sd0, 1'b0, 1'b0, 12'd2048, 12'd2048}},
    '{KIND_MEASURE, 12'd1500, 12'd2600, 1'b0, 1'b0, '0},
    '{KIND_MEASURE, 12'd2500, 12'd1700, 1'b1, 1'b0, '0},
    '{KIND_MEASURE, 12'd2100, 12'd2000, 1'b0, 1'b0, '0},
    '{KIND_CAL,     12'd2730, 12'd1365, 1'b0, 1'b0, '0},
    '{KIND_MEASURE, 12'd2730, 12'd1365, 1'b1, 1'b0, '0},
    '{KIND_MEASURE, 12'd1365, 12'd2730, 1'b0, 1'b0, '0},
    '{KIND_CAL,     12'd1365, 12'd2730, 1'b1, 1'b0, '0}
  };

  // offset from center, deadzone, scale by 100/2048 toward zero, clamp
  function automatic logic signed [VALUE_W-1:0] axis_deflection(
      logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] c);
    int off, mag, v;
    off = int'(s) - int'(c);
    mag = (off < 0) ? -off : off;
    if (mag < int'(dz_now)) off = 0;
    v = (off * FULL_DEFL) / (1 << HALF_SPAN_SHIFT);
    if (v > FULL_DEFL) v = FULL_DEFL;
    if (v < -FULL_DEFL) v = -FULL_DEFL;
    return v[VALUE_W-1:0];
  endfunction

  // one accepted sample -> expected reading, updating centers and sums
  function automatic reading_t condition_sample(kind_t k, logic [SAMPLE_W-1:0] xs,
      logic [SAMPLE_W-1:0] ys, logic lvl);
    reading_t r;
    int cx, cy;
    r = '0;
    if (k == KIND_MEASURE) begin
      r.x_value = axis_deflection(xs, ctr_x);
      r.y_value = axis_deflection(ys, ctr_y);
    end else begin
      acc_x = acc_x + int'(xs);
      acc_y = acc_y + int'(ys);
      acc_n = acc_n + 1;
      if (acc_n >= CAL_SAMPLES) begin
        cx = acc_x / CAL_SAMPLES;
        cy = acc_y / CAL_SAMPLES;
        // an implausible mean on either axis falls back to mid-scale
        if (cx > int'(CENTER_LIMIT) || cy > int'(CENTER_LIMIT)) begin
          cx = DEFAULT_CENTER;
          cy = DEFAULT_CENTER;
        end
        ctr_x = cx[SAMPLE_W-1:0];
        ctr_y = cy[SAMPLE_W-1:0];
        acc_x = 0;
        acc_y = 0;
        acc_n = 0;
        r.calibration_done = 1'b1;
      end
    end
    r.button_down = ~lvl;
    r.center_x = ctr_x;
    r.center_y = ctr_y;
    return r;
  endfunction

  // predict on each input transfer
  always @(posedge clk) begin : predict_inputs
    reading_t r;
    if (!rst && in_xfer) begin
      r = condition_sample(samples_if.kind, samples_if.x_sample, samples_if.y_sample,
                           samples_if.button_level);
      if (cur_typed) r = cur_want;
      expected_readings.push_back(r);
    end
  end

  task automatic log_mismatch(string what, reading_t want, reading_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display({"%0t %s: exp x=%0d y=%0d btn=%0b done=%0b cx=%0d cy=%0d",
                " | got x=%0d y=%0d btn=%0b done=%0b cx=%0d cy=%0d"},
               $realtime, what, want.x_value, want.y_value, want.button_down,
               want.calibration_done, want.center_x, want.center_y, got.x_value, got.y_value,
               got.button_down, got.calibration_done, got.center_x, got.center_y);
  endtask

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_readings
    reading_t got, want;
    if (!rst && out_xfer) begin
      got = '{results_if.x_value, results_if.y_value, results_if.button_down,
              results_if.calibration_done, results_if.center_x_out, results_if.center_y_out};
      if (expected_readings.size() == 0) begin
        log_mismatch("unexpected reading", '0, got);
      end else begin
        want = expected_readings.pop_front();
        if (got.x_value !== want.x_value || got.y_value !== want.y_value ||
            got.button_down !== want.button_down ||
            got.calibration_done !== want.calibration_done ||
            got.center_x !== want.center_x || got.center_y !== want.center_y)
          log_mismatch("reading mismatch", want, got);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    results_if.ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= snk_idle);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || in_xfer || out_xfer) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one sample and hold it until transfer
  task automatic send_sample(kind_t k, logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
      logic lvl, bit typed, reading_t want);
    while ($urandom_range(0, 99) < src_idle) begin
      samples_if.valid <= 1'b0;
      @(posedge clk);
    end
    samples_if.valid        <= 1'b1;
    samples_if.kind         <= k;
    samples_if.x_sample     <= xs;
    samples_if.y_sample     <= ys;
    samples_if.button_level <= lvl;
    cur_typed               <= typed;
    cur_want                <= want;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // measure sample biased toward the deadzone edge, center and rails
  function automatic logic [SAMPLE_W-1:0] pick_axis(logic [SAMPLE_W-1:0] c);
    int v, d;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 4095);
      1: begin
        d = int'(dz_now) - int'($urandom_range(0, 1));
        v = $urandom_range(0, 1) ? int'(c) + d : int'(c) - d;
      end
      2: v = $urandom_range(0, 1) ? 4095 : 0;
      default: v = int'(c) + int'($urandom_range(0, 600)) - 300;
    endcase
    return clamp_sample(v);
  endfunction

  task automatic send_measure();
    send_sample(KIND_MEASURE, pick_axis(ctr_x), pick_axis(ctr_y), 1'($urandom_range(0, 1)),
                1'b0, '0);
  endtask

  // calibration target per axis: rails, just around the limit, or mid-range
  function automatic int cal_target();
    case ($urandom_range(0, 9))
      0: return 4095;
      1: return 0;
      2: return 3995 + $urandom_range(0, 10);
      default: return $urandom_range(100, 3900);
    endcase
  endfunction

  // calibration run, mostly complete, sometimes cut short, with measures mixed in
  task automatic calibration_run();
    int tx, ty, jx, jy, n, i;
    tx = cal_target();
    ty = cal_target();
    jx = (tx == 0 || tx == 4095) ? 0 : $urandom_range(0, 80);
    jy = (ty == 0 || ty == 4095) ? 0 : $urandom_range(0, 80);
    n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 60) : CAL_SAMPLES - acc_n;
    if (n < 1) n = 1;
    i = 0;
    while (i < n) begin
      if ($urandom_range(0, 99) < 12) begin
        send_measure();
      end else begin
        send_sample(KIND_CAL, clamp_sample(tx + int'($urandom_range(0, 2 * jx)) - jx),
                    clamp_sample(ty + int'($urandom_range(0, 2 * jy)) - jy),
                    1'($urandom_range(0, 1)), 1'b0, '0);
        i++;
      end
    end
  endtask

  // deadzone write once all pending readings are back
  task automatic write_deadzone(logic [SAMPLE_W-1:0] v);
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dz_now = v;
  endtask

  // main sequence
  initial begin : stimulus
    logic [SAMPLE_W-1:0] dz_list [PHASES];
    int ph, phase_end, n, k;
    dz_now = DEADZONE_RESET;
    items_sent = 0;
    src_idle = 7;
    snk_idle = 49;
    cur_typed = 1'b0;
    cur_want = '0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    samples_if.valid <= 1'b0;
    samples_if.kind <= KIND_MEASURE;
    samples_if.x_sample <= '0;
    samples_if.y_sample <= '0;
    samples_if.button_level <= 1'b1;
    dz_list = '{12'd0, 12'd4095, 12'd1, 12'($urandom_range(2, 600)), 12'd2048,
                12'(DEADZONE_RESET)};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed rows at the reset deadzone
    for (k = 0; k < DIRECTED_COUNT; k++)
      send_sample(directed_rows[k].kind, directed_rows[k].x_sample, directed_rows[k].y_sample,
                  directed_rows[k].button_level, directed_rows[k].typed,
                  directed_rows[k].want);

    // random phases, each with its own deadzone; each pair of phases shares an idle pattern
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin src_idle = 7;  snk_idle = 49; end
        1: begin src_idle = 49; snk_idle = 7;  end
        default: begin src_idle = 0; snk_idle = 0; end
      endcase
      write_deadzone(dz_list[ph]);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: calibration_run();
          4: begin
            // noise: any kind, any value
            n = $urandom_range(1, 10);
            repeat (n)
              send_sample(kind_t'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                          12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)), 1'b0, '0);
          end
          default: begin
            n = $urandom_range(1, 40);
            repeat (n) send_measure();
          end
        endcase
      end
    end

    // drain
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/jac_pkg.sv
rtl/jac_if.sv
rtl/joystick_axis_conditioner.sv
bench/tb_joystick_axis_conditioner.sv
